// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, quiet during rst
`define SIK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sik assertion failed");

// next-cycle implication, checked on clk, quiet during rst
`define SIK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sik assertion failed");

`endif

// ===== hw/rtl/sik_pkg.sv =====
`default_nettype none

package sik_pkg;

  localparam int MODULE_COUNT = 3;
  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 17;

  // pi/1800 in Q24
  localparam logic signed [16:0] WRAD_Q24      = 17'sd29282;
  // 180 deg in 0.01 deg / 4096 units
  localparam logic signed [28:0] ANG_HALF_TURN = 29'sd73728000;
  localparam logic signed [16:0] ANG_LIMIT     = 17'sd18000;

  // register indexes
  localparam logic [2:0] REG_POS_A     = 3'd0;
  localparam logic [2:0] REG_POS_B     = 3'd1;
  localparam logic [2:0] REG_POS_C     = 3'd2;
  localparam logic [2:0] REG_TRANS_DZ  = 3'd3;
  localparam logic [2:0] REG_ROT_DZ    = 3'd4;
  localparam logic [2:0] REG_MAX_SPEED = 3'd5;

  // classified command as queued between front and back
  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
    logic               stop;
  } cmd_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_SUM, ST_ROUND, ST_SQR, ST_SQADD, ST_SQRT,
    ST_PREP, ST_DIV, ST_ANGI, ST_NORM, ST_CORD, ST_ANGR, ST_OUT
  } state_t;

  // atan(2^-i) in 0.01 deg / 4096 units
  function automatic logic [24:0] atan_entry(input logic [4:0] i);
    logic [24:0] r;
    case (i)
      5'd0:  r = 25'd18432000;
      5'd1:  r = 25'd10881045;
      5'd2:  r = 25'd5749245;
      5'd3:  r = 25'd2918407;
      5'd4:  r = 25'd1464867;
      5'd5:  r = 25'd733147;
      5'd6:  r = 25'd366663;
      5'd7:  r = 25'd183343;
      5'd8:  r = 25'd91673;
      5'd9:  r = 25'd45837;
      5'd10: r = 25'd22918;
      5'd11: r = 25'd11459;
      5'd12: r = 25'd5730;
      5'd13: r = 25'd2865;
      5'd14: r = 25'd1432;
      5'd15: r = 25'd716;
      5'd16: r = 25'd358;
      5'd17: r = 25'd179;
      5'd18: r = 25'd90;
      5'd19: r = 25'd45;
      5'd20: r = 25'd22;
      5'd21: r = 25'd11;
      5'd22: r = 25'd6;
      5'd23: r = 25'd3;
      default: r = 25'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sik_queue.sv =====
`default_nettype none

module sik_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sik_pkg::cmd_t   push_data,
  input  wire logic            pop,
  output sik_pkg::cmd_t        head,
  output sik_pkg::qstat_t      stat
);

  sik_pkg::cmd_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // two-entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

endmodule

`default_nettype wire

// ===== hw/rtl/sik_front.sv =====
`default_nettype none

module sik_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] vel_x,
  input  wire logic signed [15:0] vel_y,
  input  wire logic signed [15:0] yaw_rate,
  input  wire logic [15:0]        trans_dz,
  input  wire logic [14:0]        rot_dz,
  input  wire sik_pkg::qstat_t    stat,
  output logic                    push,
  output sik_pkg::cmd_t           push_data
);

  logic               stopped_flag;
  logic signed [31:0] sq_x;
  logic signed [31:0] sq_y;
  logic [31:0]        mag2;
  logic [31:0]        dz2;
  logic [16:0]        om_mag;
  logic               trans_zero;
  logic               rot_zero;
  logic               all_zero;
  logic               accept;

  // deadzone classification
  always_comb begin
    sq_x       = vel_x * vel_x;
    sq_y       = vel_y * vel_y;
    mag2       = 32'(sq_x) + 32'(sq_y);
    dz2        = trans_dz * trans_dz;
    trans_zero = (mag2 < dz2);
    om_mag     = yaw_rate[15] ? 17'(-{yaw_rate[15], yaw_rate}) : {1'b0, yaw_rate};
    rot_zero   = (om_mag < {2'b0, rot_dz});
    all_zero   = (trans_zero || (vel_x == 16'sd0 && vel_y == 16'sd0))
                 && (rot_zero || yaw_rate == 16'sd0);
  end

  assign in_ready = !stat.full;
  assign accept   = in_valid && in_ready;

  // repeated stop commands are dropped here
  always_comb begin
    push_data.vel_x    = trans_zero ? 16'sd0 : vel_x;
    push_data.vel_y    = trans_zero ? 16'sd0 : vel_y;
    push_data.yaw_rate = rot_zero ? 16'sd0 : yaw_rate;
    push_data.stop     = all_zero;
    push               = accept && !(all_zero && stopped_flag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stopped_flag <= 1'b0;
    end else if (accept) begin
      stopped_flag <= all_zero;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sik_back.sv =====
`default_nettype none

module sik_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sik_pkg::cmd_t   head,
  input  wire sik_pkg::qstat_t stat,
  output logic                 pop,
  input  wire logic [31:0]     pos_a,
  input  wire logic [31:0]     pos_b,
  input  wire logic [31:0]     pos_c,
  input  wire logic [15:0]     speed_cap,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [1:0]           module_index,
  output logic signed [15:0]   steer_angle,
  output logic [15:0]          drive_speed,
  output logic                 halt,
  output logic                 last_module
);

  sik_pkg::state_t state;
  sik_pkg::state_t state_next;
  sik_pkg::cmd_t   cmd;

  logic [1:0]  k;
  logic [5:0]  cnt;

  logic signed [31:0] pxw, pyw;
  logic signed [47:0] tx, ty;
  logic signed [47:0] ax, ay;
  logic signed [31:0] wx, wy;
  logic signed [63:0] sqx, sqy;
  logic [62:0] rad, res, bitm;
  logic [62:0] sq_try, sq_res_nx;
  logic        sq_fit;
  logic [31:0] spd [3];
  logic signed [31:0] wxs [3];
  logic signed [31:0] wys [3];
  logic [31:0] fastest;
  logic [48:0] num, dsh;
  logic [16:0] quo;
  logic signed [33:0] cx, cy;
  logic signed [28:0] cz;
  logic [15:0] wspd;
  logic signed [15:0] steer;

  logic [31:0] pos_sel;
  logic signed [15:0] pos_x, pos_y;
  logic        scale;
  logic [33:0] abs_x, abs_y, mag;
  logic signed [31:0] src_x, src_y;
  logic signed [33:0] sh_x, sh_y;
  logic signed [28:0] atan_s;
  logic signed [28:0] zr;
  logic signed [16:0] ang_r;
  logic [23:0] nsc;

  function automatic logic signed [31:0] round16(input logic signed [47:0] v);
    logic [47:0] m;
    logic [47:0] s;
    m = v[47] ? 48'(-v) : 48'(v);
    s = m + 48'h8000;
    return v[47] ? -$signed(s[47:16]) : $signed(s[47:16]);
  endfunction

  // module position select
  always_comb begin
    case (k)
      2'd0:    pos_sel = pos_a;
      2'd1:    pos_sel = pos_b;
      default: pos_sel = pos_c;
    endcase
    pos_x = $signed(pos_sel[31:16]);
    pos_y = $signed(pos_sel[15:0]);
  end

  // square root step and helpers
  always_comb begin
    sq_try    = res + bitm;
    sq_fit    = (rad >= sq_try);
    sq_res_nx = sq_fit ? ((res >> 1) + bitm) : (res >> 1);
    scale     = (fastest > {8'd0, speed_cap, 8'd0});
    nsc       = 24'((spd[k] + 32'd128) >> 8);
    src_x     = cmd.stop ? 32'(pos_x) : wxs[k];
    src_y     = cmd.stop ? 32'(pos_y) : wys[k];
    abs_x     = cx[33] ? 34'(-cx) : 34'(cx);
    abs_y     = cy[33] ? 34'(-cy) : 34'(cy);
    mag       = (abs_x > abs_y) ? abs_x : abs_y;
    sh_x      = cx >>> cnt;
    sh_y      = cy >>> cnt;
    atan_s    = $signed({4'd0, sik_pkg::atan_entry(cnt[4:0])});
    zr        = (cz + 29'sd2048) >>> 12;
    if (zr > 29'(sik_pkg::ANG_LIMIT)) begin
      ang_r = sik_pkg::ANG_LIMIT;
    end else if (zr < -29'(sik_pkg::ANG_LIMIT)) begin
      ang_r = -sik_pkg::ANG_LIMIT;
    end else begin
      ang_r = zr[16:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sik_pkg::ST_IDLE: begin
        if (!stat.empty) begin
          state_next = head.stop ? sik_pkg::ST_PREP : sik_pkg::ST_MUL1;
        end
      end
      sik_pkg::ST_MUL1:  state_next = sik_pkg::ST_MUL2;
      sik_pkg::ST_MUL2:  state_next = sik_pkg::ST_SUM;
      sik_pkg::ST_SUM:   state_next = sik_pkg::ST_ROUND;
      sik_pkg::ST_ROUND: state_next = sik_pkg::ST_SQR;
      sik_pkg::ST_SQR:   state_next = sik_pkg::ST_SQADD;
      sik_pkg::ST_SQADD: state_next = sik_pkg::ST_SQRT;
      sik_pkg::ST_SQRT: begin
        if (cnt == 6'(sik_pkg::SQRT_STEPS - 1)) begin
          state_next = (k == 2'(sik_pkg::MODULE_COUNT - 1)) ? sik_pkg::ST_PREP
                                                             : sik_pkg::ST_MUL1;
        end
      end
      sik_pkg::ST_PREP: begin
        state_next = (!cmd.stop && scale) ? sik_pkg::ST_DIV : sik_pkg::ST_ANGI;
      end
      sik_pkg::ST_DIV: begin
        if (cnt == 6'(sik_pkg::DIV_STEPS - 1)) begin
          state_next = sik_pkg::ST_ANGI;
        end
      end
      sik_pkg::ST_ANGI: begin
        state_next = (src_x == 32'sd0 && src_y == 32'sd0) ? sik_pkg::ST_ANGR
                                                         : sik_pkg::ST_NORM;
      end
      sik_pkg::ST_NORM: begin
        if (mag[33:29] != 5'd0) begin
          state_next = sik_pkg::ST_CORD;
        end
      end
      sik_pkg::ST_CORD: begin
        if (cnt == 6'(sik_pkg::CORDIC_STEPS - 1)) begin
          state_next = sik_pkg::ST_ANGR;
        end
      end
      sik_pkg::ST_ANGR: state_next = sik_pkg::ST_OUT;
      sik_pkg::ST_OUT: begin
        if (out_ready) begin
          state_next = (k == 2'(sik_pkg::MODULE_COUNT - 1)) ? sik_pkg::ST_IDLE
                                                             : sik_pkg::ST_PREP;
        end
      end
      default: state_next = sik_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    pop       = (state == sik_pkg::ST_IDLE) && !stat.empty;
    out_valid = (state == sik_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sik_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      k   <= 2'd0;
      cnt <= 6'd0;
    end else begin
      case (state)
        sik_pkg::ST_IDLE: begin
          cmd     <= head;
          k       <= 2'd0;
          fastest <= 32'd0;
        end
        sik_pkg::ST_MUL1: begin
          pxw <= cmd.yaw_rate * pos_x;
          pyw <= cmd.yaw_rate * pos_y;
        end
        sik_pkg::ST_MUL2: begin
          tx <= pxw * sik_pkg::WRAD_Q24;
          ty <= pyw * sik_pkg::WRAD_Q24;
        end
        sik_pkg::ST_SUM: begin
          ax <= $signed({{8{cmd.vel_x[15]}}, cmd.vel_x, 24'd0}) - ty;
          ay <= $signed({{8{cmd.vel_y[15]}}, cmd.vel_y, 24'd0}) + tx;
        end
        sik_pkg::ST_ROUND: begin
          wx <= round16(ax);
          wy <= round16(ay);
        end
        sik_pkg::ST_SQR: begin
          sqx <= wx * wx;
          sqy <= wy * wy;
        end
        sik_pkg::ST_SQADD: begin
          rad  <= sqx[62:0] + sqy[62:0];
          res  <= 63'd0;
          bitm <= 63'd1 << 62;
          cnt  <= 6'd0;
        end
        sik_pkg::ST_SQRT: begin
          if (sq_fit) begin
            rad <= rad - sq_try;
          end
          res  <= sq_res_nx;
          bitm <= bitm >> 2;
          cnt  <= cnt + 6'd1;
          if (cnt == 6'(sik_pkg::SQRT_STEPS - 1)) begin
            spd[k] <= sq_res_nx[31:0];
            wxs[k] <= wx;
            wys[k] <= wy;
            if (sq_res_nx[31:0] > fastest) begin
              fastest <= sq_res_nx[31:0];
            end
            k <= (k == 2'(sik_pkg::MODULE_COUNT - 1)) ? 2'd0 : k + 2'd1;
          end
        end
        sik_pkg::ST_PREP: begin
          num  <= {48'(spd[k]) * 48'(speed_cap), 1'b0} + {17'd0, fastest};
          dsh  <= {fastest, 1'b0, 16'd0};
          quo  <= 17'd0;
          cnt  <= 6'd0;
          if (cmd.stop) begin
            wspd <= 16'd0;
          end else if (nsc[23:16] != 8'd0) begin
            wspd <= 16'hFFFF;
          end else begin
            wspd <= nsc[15:0];
          end
        end
        sik_pkg::ST_DIV: begin
          if (num >= dsh) begin
            num <= num - dsh;
            quo <= {quo[15:0], 1'b1};
          end else begin
            quo <= {quo[15:0], 1'b0};
          end
          dsh <= dsh >> 1;
          cnt <= cnt + 6'd1;
        end
        sik_pkg::ST_ANGI: begin
          if (!cmd.stop && scale) begin
            wspd <= quo[16] ? 16'hFFFF : quo[15:0];
          end
          cnt <= 6'd0;
          if (src_x < 32'sd0) begin
            cz <= (src_y >= 32'sd0) ? sik_pkg::ANG_HALF_TURN : -sik_pkg::ANG_HALF_TURN;
            cx <= -34'(src_x);
            cy <= -34'(src_y);
          end else begin
            cz <= 29'sd0;
            cx <= 34'(src_x);
            cy <= 34'(src_y);
          end
        end
        sik_pkg::ST_NORM: begin
          if (mag[33:25] == 9'd0) begin
            cx <= cx <<< 4;
            cy <= cy <<< 4;
          end else if (mag[33:29] == 5'd0) begin
            cx <= cx <<< 1;
            cy <= cy <<< 1;
          end
        end
        sik_pkg::ST_CORD: begin
          if (cy > 34'sd0) begin
            cx <= cx + sh_y;
            cy <= cy - sh_x;
            cz <= cz + atan_s;
          end else begin
            cx <= cx - sh_y;
            cy <= cy + sh_x;
            cz <= cz - atan_s;
          end
          cnt <= cnt + 6'd1;
        end
        sik_pkg::ST_ANGR: begin
          steer <= ang_r[15:0];
        end
        sik_pkg::ST_OUT: begin
          if (out_ready) begin
            k <= k + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign module_index = k;
  assign steer_angle  = steer;
  assign drive_speed  = wspd;
  assign halt         = cmd.stop;
  assign last_module  = (k == 2'(sik_pkg::MODULE_COUNT - 1));

endmodule

`default_nettype wire

// ===== hw/rtl/swerve_inverse_kinematics_top.sv =====
// Swerve inverse kinematics for three wheel modules. A body velocity item
// (vel_x, vel_y, yaw_rate) gives three result items, one per module in order
// 0, 1, 2, with last_module set on the third; a stop command that repeats the
// previous stop gives none. The front takes an item whenever its two-entry
// queue has room; the back works one command at a time. A drive command
// runs per module the multiply, rounding and a 32-step square root, then
// per module 17 divider steps when common scaling applies, 2 to 11
// normalize steps and 24 CORDIC steps plus setup, rounding and output (a
// zero wheel vector skips normalize and CORDIC), and waits out output
// stalls; a stop command skips the square root and divider. The square
// root, divider and CORDIC are serial. Registers are written through
// cfg_we / cfg_index / cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce.
`default_nettype none

module swerve_inverse_kinematics_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] vel_x,
  input  wire logic signed [15:0] vel_y,
  input  wire logic signed [15:0] yaw_rate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              module_index,
  output logic signed [15:0]      steer_angle,
  output logic [15:0]             drive_speed,
  output logic                    halt,
  output logic                    last_module
);

  logic [31:0] pos_a, pos_b, pos_c;
  logic [15:0] trans_dz;
  logic [14:0] rot_dz;
  logic [15:0] speed_cap;

  logic            push;
  logic            pop;
  sik_pkg::cmd_t   push_data;
  sik_pkg::cmd_t   head;
  sik_pkg::qstat_t stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_a     <= 32'd0;
      pos_b     <= 32'd0;
      pos_c     <= 32'd0;
      trans_dz  <= 16'd0;
      rot_dz    <= 15'd0;
      speed_cap <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        sik_pkg::REG_POS_A:     pos_a     <= cfg_data;
        sik_pkg::REG_POS_B:     pos_b     <= cfg_data;
        sik_pkg::REG_POS_C:     pos_c     <= cfg_data;
        sik_pkg::REG_TRANS_DZ:  trans_dz  <= cfg_data[15:0];
        sik_pkg::REG_ROT_DZ:    rot_dz    <= cfg_data[14:0];
        sik_pkg::REG_MAX_SPEED: speed_cap <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  sik_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .yaw_rate  (yaw_rate),
    .trans_dz  (trans_dz),
    .rot_dz    (rot_dz),
    .stat      (stat),
    .push      (push),
    .push_data (push_data)
  );

  sik_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  sik_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .stat         (stat),
    .pop          (pop),
    .pos_a        (pos_a),
    .pos_b        (pos_b),
    .pos_c        (pos_c),
    .speed_cap    (speed_cap),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .module_index (module_index),
    .steer_angle  (steer_angle),
    .drive_speed  (drive_speed),
    .halt         (halt),
    .last_module  (last_module)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sik_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module sik_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         module_index,
  input wire logic signed [15:0] steer_angle,
  input wire logic [15:0]        drive_speed,
  input wire logic               halt,
  input wire logic               last_module
);

  // stalled result stays valid and keeps its steering angle
  `SIK_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(steer_angle))

  // stop results never drive the wheel
  `SIK_ASSERT_IMP(a_stop_zero, out_valid && halt, drive_speed == 16'd0)

  // last flag marks exactly the third module
  `SIK_ASSERT_IMP(a_last, out_valid, last_module == (module_index == 2'd2))

  // steering angle stays within half a turn
  `SIK_ASSERT_IMP(a_angle, out_valid, (steer_angle <= 16'sd18000) && (steer_angle >= -16'sd18000))

endmodule

bind swerve_inverse_kinematics_top sik_checker u_sik_checker (.*);

`default_nettype wire

// ===== tb/swerve_inverse_kinematics_top_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

module swerve_inverse_kinematics_top_tb;

  // one expected module target
  typedef struct packed {
    logic [1:0]         module_index;
    logic signed [15:0] steer_angle;
    logic [15:0]        drive_speed;
    logic               halt;
    logic               last_module;
  } target_t;

  // atan(2^-i) in 0.01 deg / 4096 units
  localparam longint ATAN_UNITS [sik_pkg::CORDIC_STEPS] = '{
    18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663, 183343,
    91673, 45837, 22918, 11459, 5730, 2865, 1432, 716,
    358, 179, 90, 45, 22, 11, 6, 3
  };

  // kinematics predictor with its own copy of the registers
  class kinematics_scoreboard;
    logic [31:0] position [sik_pkg::MODULE_COUNT];
    logic [15:0] trans_dz;
    logic [14:0] rot_dz;
    logic [15:0] speed_cap;
    bit          stopped;
    target_t     pending [$];
    int          mismatches;
    int          targets_seen;
    int          stop_cmds;

    function void clear();
      foreach (position[i]) position[i] = '0;
      trans_dz = '0;
      rot_dz = '0;
      speed_cap = 16'hffff;
      stopped = 0;
      pending.delete();
      mismatches = 0;
      targets_seen = 0;
      stop_cmds = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        sik_pkg::REG_POS_A, sik_pkg::REG_POS_B, sik_pkg::REG_POS_C: position[idx] = data;
        sik_pkg::REG_TRANS_DZ:  trans_dz = data[15:0];
        sik_pkg::REG_ROT_DZ:    rot_dz = data[14:0];
        sik_pkg::REG_MAX_SPEED: speed_cap = data[15:0];
        default: ;
      endcase
    endfunction

    function longint floor_sh(longint v, int s);
      return v >>> s;
    endfunction

    function longint round_sh(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (longint'(1) << (s - 1))) >> s;
      return (v < 0) ? -m : m;
    endfunction

    function longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint heading(longint x, longint y);
      longint z, m, ay, dx, dy, r;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? longint'(sik_pkg::ANG_HALF_TURN) : -longint'(sik_pkg::ANG_HALF_TURN);
        x = -x;
        y = -y;
      end
      ay = (y < 0) ? -y : y;
      m = (x > ay) ? x : ay;
      while (m < (longint'(1) << 29)) begin
        x *= 2;
        y *= 2;
        m *= 2;
      end
      for (int i = 0; i < sik_pkg::CORDIC_STEPS; i++) begin
        dx = floor_sh(y, i);
        dy = floor_sh(x, i);
        if (y > 0) begin
          x += dx;
          y -= dy;
          z += ATAN_UNITS[i];
        end else begin
          x -= dx;
          y += dy;
          z -= ATAN_UNITS[i];
        end
      end
      r = floor_sh(z + 2048, 12);
      if (r > 18000) r = 18000;
      if (r < -18000) r = -18000;
      return r;
    endfunction

    function void push(int k, longint ang, longint unsigned spd, bit stop);
      target_t t;
      t.module_index = k[1:0];
      t.steer_angle = ang[15:0];
      t.drive_speed = (spd > 65535) ? 16'hffff : spd[15:0];
      t.halt = stop;
      t.last_module = (k == sik_pkg::MODULE_COUNT - 1);
      pending.push_back(t);
    endfunction

    // note one accepted command
    function void note_command(logic signed [15:0] ivx, logic signed [15:0] ivy,
                               logic signed [15:0] iom);
      longint vx, vy, om, px, py, ax, ay, wx, wy;
      longint unsigned spd [sik_pkg::MODULE_COUNT];
      longint unsigned fastest, s;
      longint wxs [sik_pkg::MODULE_COUNT], wys [sik_pkg::MODULE_COUNT];
      vx = ivx;
      vy = ivy;
      om = iom;
      fastest = 0;
      if (vx * vx + vy * vy < longint'(trans_dz) * longint'(trans_dz)) begin
        vx = 0;
        vy = 0;
      end
      if (((om < 0) ? -om : om) < longint'(rot_dz)) om = 0;
      if (vx == 0 && vy == 0 && om == 0) begin
        if (stopped) return;
        stopped = 1;
        stop_cmds++;
        for (int k = 0; k < sik_pkg::MODULE_COUNT; k++) begin
          px = $signed(position[k][31:16]);
          py = $signed(position[k][15:0]);
          push(k, heading(px, py), 0, 1);
        end
        return;
      end
      stopped = 0;
      for (int k = 0; k < sik_pkg::MODULE_COUNT; k++) begin
        px = $signed(position[k][31:16]);
        py = $signed(position[k][15:0]);
        ax = vx * (longint'(1) << 24) - om * py * longint'(sik_pkg::WRAD_Q24);
        ay = vy * (longint'(1) << 24) + om * px * longint'(sik_pkg::WRAD_Q24);
        wx = round_sh(ax, 16);
        wy = round_sh(ay, 16);
        wxs[k] = wx;
        wys[k] = wy;
        spd[k] = int_sqrt(longint'(wx * wx) + longint'(wy * wy));
        if (spd[k] > fastest) fastest = spd[k];
      end
      for (int k = 0; k < sik_pkg::MODULE_COUNT; k++) begin
        if (fastest > longint'(speed_cap) * 256)
          s = (2 * spd[k] * speed_cap + fastest) / (2 * fastest);
        else
          s = (spd[k] + 128) >> 8;
        push(k, heading(wxs[k], wys[k]), s, 0);
      end
    endfunction

    // compare one result against the oldest expectation
    function void check_target(target_t got);
      target_t e;
      targets_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: idx %0d ang %0d spd %0d", got.module_index,
                   got.steer_angle, got.drive_speed);
        return;
      end
      e = pending.pop_front();
      if (got != e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp idx %0d ang %0d spd %0d stop %0b last %0b / got %0d %0d %0d %0b %0b",
                   e.module_index, e.steer_angle, e.drive_speed, e.halt, e.last_module,
                   got.module_index, got.steer_angle, got.drive_speed, got.halt,
                   got.last_module);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [15:0] vel_x = '0, vel_y = '0, yaw_rate = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] module_index;
  logic signed [15:0] steer_angle;
  logic [15:0] drive_speed;
  logic halt, last_module;

  kinematics_scoreboard board = new();
  int cycles = 0;
  int cmds_sent = 0;
  bit hold_off = 0;
  bit stall_on = 1;

  swerve_inverse_kinematics_top i_dut (.*);

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    target_t t;
    if (!rst && out_valid && out_ready) begin
      t.module_index = module_index;
      t.steer_angle = steer_angle;
      t.drive_speed = drive_speed;
      t.halt = halt;
      t.last_module = last_module;
      board.check_target(t);
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (hold_off) out_ready <= 0;
    else if (!stall_on) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    board.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // offer one item and wait for acceptance
  task automatic send_command(int vx, int vy, int om);
    in_valid <= 1;
    vel_x <= 16'(vx);
    vel_y <= 16'(vy);
    yaw_rate <= 16'(om);
    do @(posedge clk); while (!in_ready);
    board.note_command(16'(vx), 16'(vy), 16'(om));
    cmds_sent++;
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 2) == 0 ? $urandom_range(1, 40) : 0;
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 60)) - 30);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_burst(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        idle_gap();
        burst = $urandom_range(1, 8);
      end
      burst--;
      if ($urandom_range(0, 9) == 0) send_command(0, 0, 0);
      else send_command($signed(pick_field()), $signed(pick_field()), $signed(pick_field()));
    end
  endtask

  task automatic random_layout();
    for (int k = 0; k < sik_pkg::MODULE_COUNT; k++)
      write_reg(3'(k), {16'($signed($urandom_range(0, 800)) - 400),
                        16'($signed($urandom_range(0, 800)) - 400)});
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: layout, extremes, deadzones, repeated stops
    write_reg(sik_pkg::REG_POS_A, {16'sd300, 16'sd0});
    write_reg(sik_pkg::REG_POS_B, {-16'sd150, 16'sd260});
    write_reg(sik_pkg::REG_POS_C, {16'h8000, 16'h7fff});
    send_command(0, 0, 0);
    send_command(0, 0, 0);
    send_command(1000, 0, 0);
    send_command(0, 0, 0);
    send_command(-1000, 0, 0);
    send_command(0, -1000, 0);
    send_command(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_command(16'sh8000, 16'sh8000, 16'sh8000);
    send_command(0, 0, 900);
    send_command(-1, 1, -1);
    drain();
    write_reg(sik_pkg::REG_TRANS_DZ, 32'd100);
    write_reg(sik_pkg::REG_ROT_DZ, 32'd50);
    write_reg(sik_pkg::REG_MAX_SPEED, 32'd1);
    send_command(60, 79, 49);
    send_command(60, 80, 49);
    send_command(99, 0, -50);
    send_command(0, 0, -49);
    send_command(3000, -2000, 700);
    drain();
    write_reg(sik_pkg::REG_POS_A, 32'h0);
    write_reg(sik_pkg::REG_TRANS_DZ, 32'hffff);
    write_reg(sik_pkg::REG_ROT_DZ, 32'h7fff);
    write_reg(sik_pkg::REG_MAX_SPEED, 32'd0);
    send_command(16'sh7fff, 0, 16'sh8000);
    send_command(16'sh8000, 16'sh8000, 16'sh7fff);
    send_command(0, 0, 0);
    drain();

    // random phases over several settings
    write_reg(sik_pkg::REG_TRANS_DZ, 32'd0);
    write_reg(sik_pkg::REG_ROT_DZ, 32'd0);
    write_reg(sik_pkg::REG_MAX_SPEED, 32'hffff);
    random_layout();
    random_burst(30);
    // long receiver hold-off while items keep coming
    fork
      begin
        hold_off = 1;
        repeat (1500) @(posedge clk);
        hold_off = 0;
      end
      random_burst(8);
    join
    drain();
    random_layout();
    write_reg(sik_pkg::REG_TRANS_DZ, 32'($urandom_range(0, 40)));
    write_reg(sik_pkg::REG_ROT_DZ, 32'($urandom_range(0, 40)));
    write_reg(sik_pkg::REG_MAX_SPEED, 32'($urandom_range(200, 3000)));
    stall_on = 0;
    random_burst(30);
    stall_on = 1;
    drain();
    write_reg(sik_pkg::REG_POS_A, 32'($urandom));
    write_reg(sik_pkg::REG_POS_B, 32'($urandom));
    write_reg(sik_pkg::REG_POS_C, 32'($urandom));
    write_reg(sik_pkg::REG_MAX_SPEED, 32'($urandom_range(1, 65535)));
    random_burst(30);
    drain();

    $display("sent %0d commands, checked %0d module targets, %0d stop commands",
             cmds_sent, board.targets_seen, board.stop_cmds);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d left over", board.mismatches, board.pending.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  initial board.clear();

endmodule

`default_nettype wire
